// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Fixed field widths, status codes and the compare result struct of the gap unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // Fixed widths of the item fields
  localparam int unsigned FIELD_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 24;  // request_bytes, free_address
  localparam int unsigned OUT_DATA_W = 16;  // payload_address, status, zero pad

  // Operation selector carried in tuser
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // Compare results of the gap unit for the entry under test
  typedef struct packed {
    logic fit;    // gap before the entry holds the request
    logic match;  // entry payload address equals the free address
  } gap_res_t;

endpackage : ffba_pkg

`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator_core.sv =====
// First-fit block allocator core: address-ordered block table in a memory,
// scanned and shifted by a small sequencer around one shared compare unit.
// Each entry is read in S_SCAN_RD and tested in S_SCAN_EV. One item at a time: a
// new request is taken only once the result of the last one has been taken.
// Reset (rst_ni low) empties the table.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Request stream
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,  // [11:0] request_bytes, [23:12] free_address
  input  wire                   s_axis_tuser_i,  // [0] func
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // [11:0] payload_address, [13:12] status
);

  // Widths derived from the arena and table size
  localparam int unsigned SW  = $clog2(ARENA_BYTES);         // stored start offset
  localparam int unsigned CW  = $clog2(ARENA_BYTES + 8192) + 1; // compare width
  localparam int unsigned IW  = $clog2(MAX_BLOCKS);          // table index
  localparam int unsigned CNW = $clog2(MAX_BLOCKS + 1);      // entry count
  localparam int unsigned DW  = SW + FIELD_W;                // table word

  localparam logic [CW-1:0]  Hdr    = CW'(HEADER_BYTES);
  localparam logic [CNW-1:0] MaxCnt = CNW'(MAX_BLOCKS);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_EV = 4'd2;
  localparam logic [3:0] S_UP_RD   = 4'd3;
  localparam logic [3:0] S_UP_WR   = 4'd4;
  localparam logic [3:0] S_INS     = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_WR   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [CNW-1:0]     count_q, count_d;
  logic [CNW-1:0]     idx_q, idx_d;
  logic [IW-1:0]      j_q, j_d;
  logic [CW-1:0]      prev_end_q, prev_end_d;
  logic               func_q;
  logic [FIELD_W-1:0] req_q;
  logic [FIELD_W-1:0] faddr_q;
  logic [CW-1:0]      need_q;
  logic [FIELD_W-1:0] res_addr_q, res_addr_d;
  status_e            res_st_q, res_st_d;

  // Table port
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [DW-1:0]      mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [DW-1:0]      mem_rdata;

  // Gap unit
  gap_res_t           gap_res;
  logic [CW-1:0]      ent_end;
  logic               at_end;
  logic               in_accept;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_DONE);
  assign m_axis_tdata_o  = {{(OUT_DATA_W - FIELD_W - STATUS_W){1'b0}}, res_st_q, res_addr_q};

  // The entry under test is the end sentinel once the scan passes the table
  assign at_end = (idx_q == count_q);

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .DW    (DW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffba_gap_unit #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .CW           (CW),
    .SW           (SW)
  ) u_gap (
    .ent_start_i    (mem_rdata[DW-1:FIELD_W]),
    .ent_payload_i  (mem_rdata[FIELD_W-1:0]),
    .use_sentinel_i (at_end),
    .prev_end_i     (prev_end_q),
    .need_i         (need_q),
    .free_addr_i    (faddr_q),
    .res_o          (gap_res),
    .ent_end_o      (ent_end)
  );

  // Sequencer: scan, then shift the table up (allocate) or down (free)
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    j_d        = j_q;
    prev_end_d = prev_end_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    mem_we     = 1'b0;
    mem_waddr  = j_q;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          idx_d      = '0;
          prev_end_d = Hdr;  // end of the start sentinel
          res_addr_d = '0;
          res_st_d   = ST_OK;
          if ((s_axis_tuser_i == FUNC_ALLOC) && (count_q == MaxCnt)) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        // Fetch the entry; past the table the sentinel stands in
        mem_re  = !at_end;
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (func_q == FUNC_ALLOC) begin
          if (gap_res.fit) begin
            if (at_end) begin
              state_d = S_INS;
            end else begin
              j_d     = IW'(count_q - CNW'(1));
              state_d = S_UP_RD;
            end
          end else if (at_end) begin
            res_st_d = ST_NOROOM;
            state_d  = S_DONE;
          end else begin
            prev_end_d = ent_end;
            idx_d      = idx_q + CNW'(1);
            state_d    = S_SCAN_RD;
          end
        end else begin
          if (at_end) begin
            res_st_d = ST_UNKNOWN;
            state_d  = S_DONE;
          end else if (gap_res.match) begin
            j_d     = idx_q[IW-1:0];
            state_d = S_DN_RD;
          end else begin
            idx_d   = idx_q + CNW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_UP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
        state_d   = S_UP_WR;
      end
      S_UP_WR: begin
        // Move entry j one place up
        mem_we    = 1'b1;
        mem_waddr = j_q + IW'(1);
        if (j_q == idx_q[IW-1:0]) begin
          state_d = S_INS;
        end else begin
          j_d     = j_q - IW'(1);
          state_d = S_UP_RD;
        end
      end
      S_INS: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_q[IW-1:0];
        mem_wdata  = {prev_end_q[SW-1:0], req_q};
        count_d    = count_q + CNW'(1);
        res_addr_d = FIELD_W'(prev_end_q + Hdr);
        state_d    = S_DONE;
      end
      S_DN_RD: begin
        if ((CNW'(j_q) + CNW'(1)) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = j_q + IW'(1);
          state_d   = S_DN_WR;
        end else begin
          count_d = count_q - CNW'(1);
          state_d = S_DONE;
        end
      end
      S_DN_WR: begin
        // Move entry j+1 one place down
        mem_we    = 1'b1;
        mem_waddr = j_q;
        j_d       = j_q + IW'(1);
        state_d   = S_DN_RD;
      end
      S_DONE: begin
        // Hold the result until taken
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working and result registers need no reset
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    j_q        <= j_d;
    prev_end_q <= prev_end_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (in_accept) begin
      func_q  <= s_axis_tuser_i;
      req_q   <= s_axis_tdata_i[FIELD_W-1:0];
      faddr_q <= s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
      need_q  <= CW'(s_axis_tdata_i[FIELD_W-1:0]) + Hdr;
    end
  end

endmodule : first_fit_block_allocator_core

`default_nettype wire

// ===== hw/rtl/ffba_table.sv =====
// Block table memory of the allocator: one write port, one read port.
// Read data is registered. No reset; entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ffba_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 24
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [DW-1:0]            wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : ffba_table

`default_nettype wire

// ===== hw/rtl/ffba_gap_unit.sv =====
// Shared compare unit of the allocator: gap fit, block end and payload match.
// Evaluates one table entry (or the end sentinel) per use. Uses ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffba_gap_unit
  import ffba_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned CW           = 14,
  parameter int unsigned SW           = 12
) (
  input  wire  [SW-1:0]      ent_start_i,
  input  wire  [FIELD_W-1:0] ent_payload_i,
  input  wire                use_sentinel_i,
  input  wire  [CW-1:0]      prev_end_i,
  input  wire  [CW-1:0]      need_i,
  input  wire  [FIELD_W-1:0] free_addr_i,
  output gap_res_t           res_o,
  output logic [CW-1:0]      ent_end_o
);

  localparam logic [CW-1:0] Hdr      = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] EndStart = CW'(ARENA_BYTES - 1 - HEADER_BYTES);

  logic [CW-1:0] start_ext;
  logic [CW-1:0] next_start;

  assign start_ext  = CW'(ent_start_i);
  assign next_start = use_sentinel_i ? EndStart : start_ext;

  assign res_o.fit   = next_start >= (prev_end_i + need_i);
  assign res_o.match = (start_ext + Hdr) == CW'(free_addr_i);
  assign ent_end_o   = start_ext + CW'(ent_payload_i) + Hdr;

endmodule : ffba_gap_unit

`default_nettype wire
